// ===== rtl/core/hpd_pkg.sv =====
// Shared types and arithmetic step functions for the homography pose pipeline.
`timescale 1ns / 1ps

package hpd_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;
  localparam int NUM_STAGES = 141;

  localparam logic [31:0] Q30_ONE   = 32'h4000_0000;
  localparam logic [31:0] S32_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN   = 32'h8000_0000;
  localparam logic [32:0] SCALE_SAT = 33'd4;
  localparam logic [63:0] SCALE_NUM = 64'h0000_0002_0000_0000;

  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] q;
  } sqs_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [30:0] q;
  } dvs_t;

  typedef struct packed {
    logic [2:0][31:0] r1;
    logic [31:0]      s;
    logic [1:0][31:0] h25;
  } cry_t;

  // One bit of a restoring square root: rem holds radicand minus q squared.
  function automatic sqs_t sqrt_step(sqs_t a, int i);
    logic [65:0] t;
    sqs_t r;
    t = (66'(a.q) << (i + 1)) + (66'd1 << (2 * i));
    r = a;
    if (t <= 66'(a.rem)) begin
      r.rem = a.rem - t[63:0];
      r.q   = a.q | (32'd1 << i);
    end
    return r;
  endfunction

  // One quotient bit of a restoring division.
  function automatic dvs_t div_step(dvs_t a, logic [32:0] den, int i);
    logic [63:0] t;
    dvs_t r;
    t = 64'(den) << i;
    r = a;
    if (a.rem >= t) begin
      r.rem = a.rem - t;
      r.q   = a.q | (31'd1 << i);
    end
    return r;
  endfunction

  function automatic logic [31:0] abs32(logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  function automatic logic [31:0] sat32(logic signed [71:0] x);
    logic [31:0] r;
    if (x > 72'sd2147483647) begin
      r = S32_MAX;
    end else if (x < -72'sd2147483648) begin
      r = S32_MIN;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/homography_pose_decompose_unit.sv =====
// Top level: pipelined homography to rotation and translation decomposition.
`timescale 1ns / 1ps
// Pipeline: 141 register stages, including two 32-stage square roots and two
// 31-stage dividers in series on the column-two path.
// Throughput: one request per cycle when not stalled; every stage advances on a
// common enable that drops only while the output register holds an untaken result.
// Reset: synchronous active-low rst_n clears the stage valid bits; payload
// registers are not reset.

module homography_pose_decompose_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_hom_0,
  input  logic [31:0] in_hom_1,
  input  logic [31:0] in_hom_2,
  input  logic [31:0] in_hom_3,
  input  logic [31:0] in_hom_4,
  input  logic [31:0] in_hom_5,
  input  logic [31:0] in_hom_6,
  input  logic [31:0] in_hom_7,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_rot_00,
  output logic [31:0] out_rot_01,
  output logic [31:0] out_rot_02,
  output logic [31:0] out_rot_10,
  output logic [31:0] out_rot_11,
  output logic [31:0] out_rot_12,
  output logic [31:0] out_rot_20,
  output logic [31:0] out_rot_21,
  output logic [31:0] out_rot_22,
  output logic [31:0] out_pos_x,
  output logic [31:0] out_pos_y,
  output logic [31:0] out_pos_z
);

  localparam int NST = hpd_pkg::NUM_STAGES;
  localparam int NSQ = hpd_pkg::SQRT_STEPS;
  localparam int NDV = hpd_pkg::DIV_STEPS;

  logic           en;
  logic [NST-1:0] vld_r;

  // Advance the whole pipe unless the output register is holding an untaken result.
  assign en        = !vld_r[NST-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // ---- Input capture -------------------------------------------------------
  logic [7:0][31:0] h_in_r;
  always_ff @(posedge clk) begin
    if (en) begin
      h_in_r <= {in_hom_7, in_hom_6, in_hom_5, in_hom_4,
                 in_hom_3, in_hom_2, in_hom_1, in_hom_0};
    end
  end

  // ---- Squares of both columns --------------------------------------------
  logic [5:0][63:0] sq1_nxt, sq1_r;
  logic [7:0][31:0] h_sq_r;
  always_comb begin
    sq1_nxt[0] = hpd_pkg::abs32(h_in_r[0]) * hpd_pkg::abs32(h_in_r[0]);
    sq1_nxt[1] = hpd_pkg::abs32(h_in_r[3]) * hpd_pkg::abs32(h_in_r[3]);
    sq1_nxt[2] = hpd_pkg::abs32(h_in_r[6]) * hpd_pkg::abs32(h_in_r[6]);
    sq1_nxt[3] = hpd_pkg::abs32(h_in_r[1]) * hpd_pkg::abs32(h_in_r[1]);
    sq1_nxt[4] = hpd_pkg::abs32(h_in_r[4]) * hpd_pkg::abs32(h_in_r[4]);
    sq1_nxt[5] = hpd_pkg::abs32(h_in_r[7]) * hpd_pkg::abs32(h_in_r[7]);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sq1_r  <= sq1_nxt;
      h_sq_r <= h_in_r;
    end
  end

  // ---- Column norms: sum of squares, then bit-per-stage square root -------
  hpd_pkg::sqs_t    iqa_r [0:NSQ];
  hpd_pkg::sqs_t    iqb_r [0:NSQ];
  logic [7:0][31:0] iqh_r [0:NSQ];

  always_ff @(posedge clk) begin
    if (en) begin
      iqa_r[0].rem <= sq1_r[0] + sq1_r[1] + sq1_r[2];
      iqa_r[0].q   <= '0;
      iqb_r[0].rem <= sq1_r[3] + sq1_r[4] + sq1_r[5];
      iqb_r[0].q   <= '0;
      iqh_r[0]     <= h_sq_r;
    end
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt1
    always_ff @(posedge clk) begin
      if (en) begin
        iqa_r[k+1] <= hpd_pkg::sqrt_step(iqa_r[k], NSQ - 1 - k);
        iqb_r[k+1] <= hpd_pkg::sqrt_step(iqb_r[k], NSQ - 1 - k);
        iqh_r[k+1] <= iqh_r[k];
      end
    end
  end

  // ---- Column one and scale: four dividers side by side -------------------
  // Lanes 0..2 divide h0, h3, -h6 (times 2^30) by n1; lane 3 divides 2^33 by
  // n1 + n2. Magnitudes go in, the sign is put back afterwards.
  hpd_pkg::dvs_t [3:0] dv1_r  [0:NDV];
  logic [32:0]         den1_r [0:NDV];
  logic [32:0]         dens_r [0:NDV];
  logic [2:0]          neg1_r [0:NDV];
  logic [2:0][32:0]    c2_r   [0:NDV];
  logic [1:0][31:0]    h25_r  [0:NDV];

  logic [7:0][31:0] hq;
  assign hq = iqh_r[NSQ];

  always_ff @(posedge clk) begin
    if (en) begin
      dv1_r[0][0].rem <= {2'b00, hpd_pkg::abs32(hq[0]), 30'd0};
      dv1_r[0][1].rem <= {2'b00, hpd_pkg::abs32(hq[3]), 30'd0};
      dv1_r[0][2].rem <= {2'b00, hpd_pkg::abs32(hq[6]), 30'd0};
      dv1_r[0][3].rem <= hpd_pkg::SCALE_NUM;
      dv1_r[0][0].q   <= '0;
      dv1_r[0][1].q   <= '0;
      dv1_r[0][2].q   <= '0;
      dv1_r[0][3].q   <= '0;
      den1_r[0]       <= {1'b0, iqa_r[NSQ].q};
      dens_r[0]       <= {1'b0, iqa_r[NSQ].q} + {1'b0, iqb_r[NSQ].q};
      // -h6 is negative when h6 is strictly positive
      neg1_r[0]       <= {!hq[6][31] && (hq[6] != 32'd0), hq[3][31], hq[0][31]};
      c2_r[0][0]      <= {hq[1][31], hq[1]};
      c2_r[0][1]      <= {hq[4][31], hq[4]};
      c2_r[0][2]      <= 33'd0 - {hq[7][31], hq[7]};
      h25_r[0]        <= {hq[5], hq[2]};
    end
  end

  for (genvar k = 0; k < NDV; k++) begin : g_div1
    always_ff @(posedge clk) begin
      if (en) begin
        dv1_r[k+1][0] <= hpd_pkg::div_step(dv1_r[k][0], den1_r[k], NDV - 1 - k);
        dv1_r[k+1][1] <= hpd_pkg::div_step(dv1_r[k][1], den1_r[k], NDV - 1 - k);
        dv1_r[k+1][2] <= hpd_pkg::div_step(dv1_r[k][2], den1_r[k], NDV - 1 - k);
        dv1_r[k+1][3] <= hpd_pkg::div_step(dv1_r[k][3], dens_r[k], NDV - 1 - k);
        den1_r[k+1]   <= den1_r[k];
        dens_r[k+1]   <= dens_r[k];
        neg1_r[k+1]   <= neg1_r[k];
        c2_r[k+1]     <= c2_r[k];
        h25_r[k+1]    <= h25_r[k];
      end
    end
  end

  // ---- Column one and scale: restore sign, saturate small divisors --------
  hpd_pkg::cry_t    f1_nxt, f1_r;
  logic [2:0][32:0] c2f_r;
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (den1_r[NDV] == 33'd0) begin
        f1_nxt.r1[j] = neg1_r[NDV][j] ? (32'd0 - hpd_pkg::Q30_ONE) : hpd_pkg::Q30_ONE;
      end else if (neg1_r[NDV][j]) begin
        f1_nxt.r1[j] = 32'd0 - {1'b0, dv1_r[NDV][j].q};
      end else begin
        f1_nxt.r1[j] = {1'b0, dv1_r[NDV][j].q};
      end
    end
    // 2^33 / den overflows 31 bits for every divisor up to four
    f1_nxt.s   = (dens_r[NDV] <= hpd_pkg::SCALE_SAT) ? hpd_pkg::S32_MAX
                                                     : {1'b0, dv1_r[NDV][3].q};
    f1_nxt.h25 = h25_r[NDV];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      f1_r  <= f1_nxt;
      c2f_r <= c2_r[NDV];
    end
  end

  // ---- Gram-Schmidt: dot products ------------------------------------------
  logic signed [64:0] dp_r [3];
  hpd_pkg::cry_t      m1_r;
  logic [2:0][32:0]   c2m_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        dp_r[j] <= $signed(f1_r.r1[j]) * $signed(c2f_r[j]);
      end
      m1_r  <= f1_r;
      c2m_r <= c2f_r;
    end
  end

  // ---- Gram-Schmidt: sum and floor to Q16.16 -------------------------------
  logic signed [66:0] dsum;
  logic signed [36:0] d_r;
  hpd_pkg::cry_t      dd_r;
  logic [2:0][32:0]   c2d_r;
  assign dsum = 67'(dp_r[0]) + 67'(dp_r[1]) + 67'(dp_r[2]);
  always_ff @(posedge clk) begin
    if (en) begin
      d_r   <= 37'(dsum >>> 30);
      dd_r  <= m1_r;
      c2d_r <= c2m_r;
    end
  end

  // ---- Gram-Schmidt: projection onto column one ---------------------------
  logic signed [68:0] rd_r [3];
  hpd_pkg::cry_t      m2_r;
  logic [2:0][32:0]   c2p_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        rd_r[j] <= $signed(dd_r.r1[j]) * d_r;
      end
      m2_r  <= dd_r;
      c2p_r <= c2d_r;
    end
  end

  // ---- Gram-Schmidt: residual, saturated ----------------------------------
  logic signed [39:0] udiff [3];
  logic [2:0][31:0]   u_r;
  hpd_pkg::cry_t      uu_r;
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      udiff[j] = 40'($signed(c2p_r[j])) - 40'(rd_r[j] >>> 30);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        u_r[j] <= hpd_pkg::sat32(72'(udiff[j]));
      end
      uu_r <= m2_r;
    end
  end

  // ---- Residual squares ----------------------------------------------------
  logic [2:0][63:0] squ_r;
  logic [2:0][31:0] uq_r;
  hpd_pkg::cry_t    uq_cry_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        squ_r[j] <= 64'(hpd_pkg::abs32(u_r[j])) * 64'(hpd_pkg::abs32(u_r[j]));
      end
      uq_r     <= u_r;
      uq_cry_r <= uu_r;
    end
  end

  // ---- Residual norm -------------------------------------------------------
  hpd_pkg::sqs_t    iqu_r  [0:NSQ];
  logic [2:0][31:0] iqv_r  [0:NSQ];
  hpd_pkg::cry_t    iqc_r  [0:NSQ];

  always_ff @(posedge clk) begin
    if (en) begin
      iqu_r[0].rem <= squ_r[0] + squ_r[1] + squ_r[2];
      iqu_r[0].q   <= '0;
      iqv_r[0]     <= uq_r;
      iqc_r[0]     <= uq_cry_r;
    end
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt2
    always_ff @(posedge clk) begin
      if (en) begin
        iqu_r[k+1] <= hpd_pkg::sqrt_step(iqu_r[k], NSQ - 1 - k);
        iqv_r[k+1] <= iqv_r[k];
        iqc_r[k+1] <= iqc_r[k];
      end
    end
  end

  // ---- Column two: three dividers by the residual norm --------------------
  hpd_pkg::dvs_t [2:0] dv2_r  [0:NDV];
  logic [32:0]         den2_r [0:NDV];
  logic [2:0]          neg2_r [0:NDV];
  hpd_pkg::cry_t       dvc_r  [0:NDV];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        dv2_r[0][j].rem <= {2'b00, hpd_pkg::abs32(iqv_r[NSQ][j]), 30'd0};
        dv2_r[0][j].q   <= '0;
        neg2_r[0][j]    <= iqv_r[NSQ][j][31];
      end
      den2_r[0] <= {1'b0, iqu_r[NSQ].q};
      dvc_r[0]  <= iqc_r[NSQ];
    end
  end

  for (genvar k = 0; k < NDV; k++) begin : g_div2
    always_ff @(posedge clk) begin
      if (en) begin
        for (int j = 0; j < 3; j++) begin
          dv2_r[k+1][j] <= hpd_pkg::div_step(dv2_r[k][j], den2_r[k], NDV - 1 - k);
        end
        den2_r[k+1] <= den2_r[k];
        neg2_r[k+1] <= neg2_r[k];
        dvc_r[k+1]  <= dvc_r[k];
      end
    end
  end

  // ---- Column two: restore sign, saturate zero divisors -------------------
  logic [2:0][31:0] r2_nxt, r2_r;
  hpd_pkg::cry_t    f2_r;
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (den2_r[NDV] == 33'd0) begin
        r2_nxt[j] = neg2_r[NDV][j] ? (32'd0 - hpd_pkg::Q30_ONE) : hpd_pkg::Q30_ONE;
      end else if (neg2_r[NDV][j]) begin
        r2_nxt[j] = 32'd0 - {1'b0, dv2_r[NDV][j].q};
      end else begin
        r2_nxt[j] = {1'b0, dv2_r[NDV][j].q};
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      r2_r <= r2_nxt;
      f2_r <= dvc_r[NDV];
    end
  end

  // ---- Cross product and translation products -----------------------------
  logic signed [63:0] xp_r [6];
  logic signed [63:0] tp_r [2];
  logic [2:0][31:0]   xr1_r, xr2_r;
  logic [31:0]        xs_r;
  always_ff @(posedge clk) begin
    if (en) begin
      xp_r[0] <= $signed(f2_r.r1[1]) * $signed(r2_r[2]);
      xp_r[1] <= $signed(f2_r.r1[2]) * $signed(r2_r[1]);
      xp_r[2] <= $signed(f2_r.r1[2]) * $signed(r2_r[0]);
      xp_r[3] <= $signed(f2_r.r1[0]) * $signed(r2_r[2]);
      xp_r[4] <= $signed(f2_r.r1[0]) * $signed(r2_r[1]);
      xp_r[5] <= $signed(f2_r.r1[1]) * $signed(r2_r[0]);
      // scale is positive, so its top bit is clear
      tp_r[0] <= $signed(f2_r.s) * $signed(f2_r.h25[0]);
      tp_r[1] <= $signed(f2_r.s) * $signed(f2_r.h25[1]);
      xr1_r   <= f2_r.r1;
      xr2_r   <= r2_r;
      xs_r    <= f2_r.s;
    end
  end

  // ---- Output register -----------------------------------------------------
  logic signed [64:0] xd [3];
  assign xd[0] = 65'(xp_r[0]) - 65'(xp_r[1]);
  assign xd[1] = 65'(xp_r[2]) - 65'(xp_r[3]);
  assign xd[2] = 65'(xp_r[4]) - 65'(xp_r[5]);

  always_ff @(posedge clk) begin
    if (en) begin
      out_rot_00 <= xr1_r[0];
      out_rot_10 <= xr1_r[1];
      out_rot_20 <= xr1_r[2];
      out_rot_01 <= xr2_r[0];
      out_rot_11 <= xr2_r[1];
      out_rot_21 <= xr2_r[2];
      out_rot_02 <= hpd_pkg::sat32(72'(xd[0] >>> 30));
      out_rot_12 <= hpd_pkg::sat32(72'(xd[1] >>> 30));
      out_rot_22 <= hpd_pkg::sat32(72'(xd[2] >>> 30));
      out_pos_x  <= hpd_pkg::sat32(72'(tp_r[0] >>> 16));
      out_pos_y  <= hpd_pkg::sat32(72'(tp_r[1] >>> 16));
      out_pos_z  <= 32'd0 - xs_r;
    end
  end

  // ---- Assertions ----------------------------------------------------------
  // A stall must freeze every stage's valid bit.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> $stable(vld_r))
    else $error("pipeline moved during stall");

  // The scale is at least one LSB, so the z translation is always negative.
  a_posz_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $signed(out_pos_z) < 0)
    else $error("pos_z not negative");

  // Column one comes from a normalizing divide and never exceeds unit size.
  a_col1_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_rot_00) <= 32'sh4000_0000) &&
                  ($signed(out_rot_00) >= -32'sh4000_0000) &&
                  ($signed(out_rot_20) <= 32'sh4000_0000) &&
                  ($signed(out_rot_20) >= -32'sh4000_0000))
    else $error("column one entry out of unit range");

endmodule
